@@ rtl/necd_pkg.sv @@
// ----------------------------------------------------------------------------
// necd_pkg
// Shared types, register codes and interval window helper for the NEC
// IR frame decoder.
// ----------------------------------------------------------------------------
package necd_pkg;

  localparam int TICK_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int FRAME_BITS = 32;
  localparam int CNT_W      = $clog2(FRAME_BITS) + 1;
  localparam int POS_W      = $clog2(FRAME_BITS);
  localparam int BYTE_W     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_START_NOM  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_NOM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_NOM   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_NOM    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 3'd4;

  localparam logic [TICK_W-1:0] START_NOM_RST  = 16'd12442;
  localparam logic [TICK_W-1:0] REPEAT_NOM_RST = 16'd10368;
  localparam logic [TICK_W-1:0] ZERO_NOM_RST   = 16'd1032;
  localparam logic [TICK_W-1:0] ONE_NOM_RST    = 16'd2074;
  localparam logic [TICK_W-1:0] TOLERANCE_RST  = 16'd500;

  // interval class hits, one per window
  typedef struct packed {
    logic start_hit;
    logic repeat_hit;
    logic zero_hit;
    logic one_hit;
  } necd_class_t;

  typedef struct packed {
    logic frame_ready;
    logic repeat_ready;
    logic check_failed;
  } necd_flags_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_LEAD = 3'b010,
    PH_RECV = 3'b100
  } necd_phase_t;

  // nom - tol < t < nom + tol, evaluated exactly in 17 bits
  function automatic logic in_window(input logic [TICK_W-1:0] t,
                                     input logic [TICK_W-1:0] nom,
                                     input logic [TICK_W-1:0] tol);
    logic [TICK_W:0] sum_t;
    logic [TICK_W:0] sum_n;
    sum_t = {1'b0, t} + {1'b0, tol};
    sum_n = {1'b0, nom} + {1'b0, tol};
    return (sum_t > {1'b0, nom}) && ({1'b0, t} < sum_n);
  endfunction

endpackage

@@ rtl/necd_classify.sv @@
// ----------------------------------------------------------------------------
// necd_classify
// Front end: holds the timing registers and sorts each interval into the
// start, repeat, zero and one windows.
// ----------------------------------------------------------------------------
module necd_classify (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [necd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [necd_pkg::TICK_W-1:0]    cfg_data,
  input  logic [necd_pkg::TICK_W-1:0]    interval_ticks,
  output necd_pkg::necd_class_t          cls
);

  logic [necd_pkg::TICK_W-1:0] start_nom;
  logic [necd_pkg::TICK_W-1:0] repeat_nom;
  logic [necd_pkg::TICK_W-1:0] zero_nom;
  logic [necd_pkg::TICK_W-1:0] one_nom;
  logic [necd_pkg::TICK_W-1:0] tolerance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_nom  <= necd_pkg::START_NOM_RST;
      repeat_nom <= necd_pkg::REPEAT_NOM_RST;
      zero_nom   <= necd_pkg::ZERO_NOM_RST;
      one_nom    <= necd_pkg::ONE_NOM_RST;
      tolerance  <= necd_pkg::TOLERANCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        necd_pkg::REG_START_NOM:  start_nom  <= cfg_data;
        necd_pkg::REG_REPEAT_NOM: repeat_nom <= cfg_data;
        necd_pkg::REG_ZERO_NOM:   zero_nom   <= cfg_data;
        necd_pkg::REG_ONE_NOM:    one_nom    <= cfg_data;
        necd_pkg::REG_TOLERANCE:  tolerance  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cls.start_hit  = necd_pkg::in_window(interval_ticks, start_nom, tolerance);
    cls.repeat_hit = necd_pkg::in_window(interval_ticks, repeat_nom, tolerance);
    cls.zero_hit   = necd_pkg::in_window(interval_ticks, zero_nom, tolerance);
    cls.one_hit    = necd_pkg::in_window(interval_ticks, one_nom, tolerance);
  end

endmodule

@@ rtl/necd_fifo.sv @@
// ----------------------------------------------------------------------------
// necd_fifo
// Two-entry queue of classified intervals between front and back end.
// ----------------------------------------------------------------------------
module necd_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  necd_pkg::necd_class_t push_data,
  output logic                  full,
  input  logic                  pop,
  output logic                  not_empty,
  output necd_pkg::necd_class_t pop_data
);

  necd_pkg::necd_class_t entries [2];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/necd_engine.sv @@
// ----------------------------------------------------------------------------
// necd_engine
// Back end: phase machine, bit assembly, complement check and the
// registered result beat.
// ----------------------------------------------------------------------------
module necd_engine (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_not_empty,
  input  necd_pkg::necd_class_t       q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output necd_pkg::necd_flags_t       flags,
  output logic [necd_pkg::BYTE_W-1:0] address_out,
  output logic [necd_pkg::BYTE_W-1:0] command_out
);

  necd_pkg::necd_phase_t         phase, phase_next;
  logic [necd_pkg::CNT_W-1:0]    bit_count, bit_count_next;
  logic [necd_pkg::FRAME_BITS-1:0] shift_data, shift_data_next;
  logic [necd_pkg::BYTE_W-1:0]   latched_address, latched_address_next;
  logic [necd_pkg::BYTE_W-1:0]   latched_command, latched_command_next;
  necd_pkg::necd_flags_t         flags_next;
  logic                          check_ok;

  assign q_pop       = q_not_empty && (!out_valid || !out_stall);
  assign address_out = latched_address;
  assign command_out = latched_command;

  always_comb begin
    phase_next           = phase;
    bit_count_next       = bit_count;
    shift_data_next      = shift_data;
    latched_address_next = latched_address;
    latched_command_next = latched_command;
    flags_next           = '0;
    check_ok             = 1'b0;
    unique case (phase)
      necd_pkg::PH_LEAD: begin
        if (q_data.start_hit) begin
          phase_next = necd_pkg::PH_RECV;
        end else if (q_data.repeat_hit) begin
          flags_next.repeat_ready = 1'b1;
          phase_next              = necd_pkg::PH_IDLE;
        end
      end
      necd_pkg::PH_RECV: begin
        if (q_data.zero_hit || q_data.one_hit) begin
          shift_data_next[bit_count[necd_pkg::POS_W-1:0]] = !q_data.zero_hit;
          bit_count_next = bit_count + 1'b1;
        end else begin
          bit_count_next = '0;
          phase_next     = necd_pkg::PH_LEAD;
        end
        if (bit_count_next >= necd_pkg::CNT_W'(necd_pkg::FRAME_BITS)) begin
          check_ok = (shift_data_next[7:0] == ~shift_data_next[15:8]) &&
                     (shift_data_next[23:16] == ~shift_data_next[31:24]);
          bit_count_next = '0;
          phase_next     = necd_pkg::PH_IDLE;
          if (check_ok) begin
            latched_address_next   = shift_data_next[7:0];
            latched_command_next   = shift_data_next[23:16];
            flags_next.frame_ready = 1'b1;
          end else begin
            flags_next.check_failed = 1'b1;
          end
        end
      end
      default: begin
        phase_next     = necd_pkg::PH_LEAD;
        bit_count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      shift_data <= shift_data_next;
      flags      <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= necd_pkg::PH_IDLE;
      bit_count       <= '0;
      latched_address <= '0;
      latched_command <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (q_pop) begin
        phase           <= phase_next;
        bit_count       <= bit_count_next;
        latched_address <= latched_address_next;
        latched_command <= latched_command_next;
        out_valid       <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0(flags))
    else $error("more than one result flag set");

  a_frame_to_idle: assert property (@(posedge clk) disable iff (rst)
    (q_pop && (flags_next.frame_ready || flags_next.check_failed))
      |=> (phase == necd_pkg::PH_IDLE) && (bit_count == '0))
    else $error("phase not idle after full frame");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    bit_count < necd_pkg::CNT_W'(necd_pkg::FRAME_BITS))
    else $error("bit count past frame length");

  a_count_only_recv: assert property (@(posedge clk) disable iff (rst)
    (bit_count != '0) |-> (phase == necd_pkg::PH_RECV))
    else $error("bit count nonzero outside reception");

  a_bytes_hold: assert property (@(posedge clk) disable iff (rst)
    !q_pop |=> $stable(latched_address) && $stable(latched_command))
    else $error("latched bytes changed without a beat");

endmodule

@@ rtl/nec_ir_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder
// Each accepted edge beat is queued and its result beat is registered at
// the engine output. Throughput: one edge beat per cycle while out_stall
// is low, set by the two-entry queue and the phase machine. in_stall rises
// only when the queue is full. Reset (rst, synchronous): phase idle, counters
// and latched bytes cleared, timing registers back to their nominal defaults.
// ----------------------------------------------------------------------------
// NEC IR frame decoder top level
// Front classifier, interval queue and back-end decode engine.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [necd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [necd_pkg::TICK_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [necd_pkg::TICK_W-1:0]    interval_ticks,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           frame_ready,
  output logic                           repeat_ready,
  output logic                           check_failed,
  output logic [necd_pkg::BYTE_W-1:0]    address_out,
  output logic [necd_pkg::BYTE_W-1:0]    command_out
);

  necd_pkg::necd_class_t cls;
  necd_pkg::necd_class_t q_data;
  necd_pkg::necd_flags_t flags;
  logic                  q_full;
  logic                  q_not_empty;
  logic                  q_pop;
  logic                  push;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  necd_classify u_classify (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .interval_ticks (interval_ticks),
    .cls            (cls)
  );

  necd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cls),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  necd_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .flags       (flags),
    .address_out (address_out),
    .command_out (command_out)
  );

  assign frame_ready  = flags.frame_ready;
  assign repeat_ready = flags.repeat_ready;
  assign check_failed = flags.check_failed;

endmodule

@@ sim/nec_ir_frame_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder_tb
// Self-checking bench for the NEC IR frame decoder. A behavioral decoder
// predicts one result beat per accepted edge beat. Directed checks cover the
// window bounds, class priority, empty and full windows. Random traffic then
// sends NEC frames, repeats and noise under several timing setups, with
// bursty input and patterned output stall.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder_tb;

  typedef struct packed {
    logic                        frame;
    logic                        rep;
    logic                        fail;
    logic [necd_pkg::BYTE_W-1:0] addr;
    logic [necd_pkg::BYTE_W-1:0] cmd;
  } edge_result_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [necd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [necd_pkg::TICK_W-1:0]    cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [necd_pkg::TICK_W-1:0]    interval_ticks = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           frame_ready;
  logic                           repeat_ready;
  logic                           check_failed;
  logic [necd_pkg::BYTE_W-1:0]    address_out;
  logic [necd_pkg::BYTE_W-1:0]    command_out;

  // decoder model state
  logic [necd_pkg::TICK_W-1:0] start_nom  = necd_pkg::START_NOM_RST;
  logic [necd_pkg::TICK_W-1:0] repeat_nom = necd_pkg::REPEAT_NOM_RST;
  logic [necd_pkg::TICK_W-1:0] zero_nom   = necd_pkg::ZERO_NOM_RST;
  logic [necd_pkg::TICK_W-1:0] one_nom    = necd_pkg::ONE_NOM_RST;
  logic [necd_pkg::TICK_W-1:0] tol_ticks  = necd_pkg::TOLERANCE_RST;
  necd_pkg::necd_phase_t       dec_phase  = necd_pkg::PH_IDLE;
  logic [5:0]                  bit_cnt    = '0;
  logic [31:0]                 shift_word = '0;
  logic [necd_pkg::BYTE_W-1:0] addr_latch = '0;
  logic [necd_pkg::BYTE_W-1:0] cmd_latch  = '0;

  edge_result_t pending_results[$];
  int           err_count  = 0;
  int           burst_left = 0;
  int           items_sent = 0;
  int           stall_left = 0;
  int           stall_mode = 0;
  int           stall_cyc  = 0;

  nec_ir_frame_decoder dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .interval_ticks (interval_ticks),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_ready    (frame_ready),
    .repeat_ready   (repeat_ready),
    .check_failed   (check_failed),
    .address_out    (address_out),
    .command_out    (command_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic ticks_fit(input logic [necd_pkg::TICK_W-1:0] t,
                                     input logic [necd_pkg::TICK_W-1:0] nom);
    int lo;
    int hi;
    lo = int'(nom) - int'(tol_ticks);
    hi = int'(nom) + int'(tol_ticks);
    return (int'(t) > lo) && (int'(t) < hi);
  endfunction

  function automatic edge_result_t decode_edge(input logic [necd_pkg::TICK_W-1:0] t);
    edge_result_t r;
    logic [4:0]   pos;
    r = '0;
    case (dec_phase)
      necd_pkg::PH_LEAD: begin
        if (ticks_fit(t, start_nom)) begin
          dec_phase = necd_pkg::PH_RECV;
        end else if (ticks_fit(t, repeat_nom)) begin
          r.rep     = 1'b1;
          dec_phase = necd_pkg::PH_IDLE;
        end
      end
      necd_pkg::PH_RECV: begin
        pos = bit_cnt[4:0];
        if (ticks_fit(t, zero_nom)) begin
          shift_word[pos] = 1'b0;
          bit_cnt         = bit_cnt + 1'b1;
        end else if (ticks_fit(t, one_nom)) begin
          shift_word[pos] = 1'b1;
          bit_cnt         = bit_cnt + 1'b1;
        end else begin
          bit_cnt   = '0;
          dec_phase = necd_pkg::PH_LEAD;
        end
        if (bit_cnt >= necd_pkg::FRAME_BITS) begin
          bit_cnt = '0;
          if (shift_word[7:0] == ~shift_word[15:8] &&
              shift_word[23:16] == ~shift_word[31:24]) begin
            addr_latch = shift_word[7:0];
            cmd_latch  = shift_word[23:16];
            r.frame    = 1'b1;
          end else begin
            r.fail = 1'b1;
          end
          dec_phase = necd_pkg::PH_IDLE;
        end
      end
      default: begin
        dec_phase = necd_pkg::PH_LEAD;
        bit_cnt   = '0;
      end
    endcase
    r.addr = addr_latch;
    r.cmd  = cmd_latch;
    return r;
  endfunction

  // random tick inside a class window, or anything when the window is empty
  function automatic logic [necd_pkg::TICK_W-1:0] tick_in(
      input logic [necd_pkg::TICK_W-1:0] nom);
    int tw;
    int v;
    tw = int'(tol_ticks);
    if (tw == 0) return necd_pkg::TICK_W'($urandom_range(0, 65535));
    v = int'(nom) + int'($urandom_range(0, 2 * (tw - 1))) - (tw - 1);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return necd_pkg::TICK_W'(v);
  endfunction

  function automatic logic [necd_pkg::TICK_W-1:0] rand_tick();
    return necd_pkg::TICK_W'($urandom_range(0, 65535));
  endfunction

  task automatic drive_edge(input logic [necd_pkg::TICK_W-1:0] ticks);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
      burst_left = int'($urandom_range(1, 40));
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    interval_ticks <= ticks;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(decode_edge(ticks));
    burst_left--;
    items_sent++;
  endtask

  task automatic wait_decoder_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [necd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [necd_pkg::TICK_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      necd_pkg::REG_START_NOM:  start_nom  = val;
      necd_pkg::REG_REPEAT_NOM: repeat_nom = val;
      necd_pkg::REG_ZERO_NOM:   zero_nom   = val;
      necd_pkg::REG_ONE_NOM:    one_nom    = val;
      necd_pkg::REG_TOLERANCE:  tol_ticks  = val;
      default: ;
    endcase
    repeat (2) @(posedge clk);
  endtask

  task automatic load_timing(input logic [necd_pkg::TICK_W-1:0] st,
                             input logic [necd_pkg::TICK_W-1:0] rp,
                             input logic [necd_pkg::TICK_W-1:0] z,
                             input logic [necd_pkg::TICK_W-1:0] o,
                             input logic [necd_pkg::TICK_W-1:0] tl);
    wait_decoder_idle();
    cfg_write(necd_pkg::REG_START_NOM, st);
    cfg_write(necd_pkg::REG_REPEAT_NOM, rp);
    cfg_write(necd_pkg::REG_ZERO_NOM, z);
    cfg_write(necd_pkg::REG_ONE_NOM, o);
    cfg_write(necd_pkg::REG_TOLERANCE, tl);
  endtask

  task automatic send_frame(input logic corrupt, input logic broken);
    logic [31:0] word;
    logic [7:0]  addr;
    logic [7:0]  cmd;
    int          nbits;
    addr = 8'($urandom_range(0, 255));
    cmd  = 8'($urandom_range(0, 255));
    word = {~cmd, cmd, ~addr, addr};
    if (corrupt) word[$urandom_range(0, 31)] ^= 1'b1;
    nbits = broken ? int'($urandom_range(1, 31)) : necd_pkg::FRAME_BITS;
    if (dec_phase == necd_pkg::PH_IDLE) drive_edge(rand_tick());
    drive_edge(tick_in(start_nom));
    for (int i = 0; i < nbits; i++) begin
      drive_edge(word[i] ? tick_in(one_nom) : tick_in(zero_nom));
    end
    if (broken) drive_edge(rand_tick());
  endtask

  task automatic test_window_edges();
    drive_edge(16'h0000);
    drive_edge(16'hFFFF);
    drive_edge(start_nom - tol_ticks);
    drive_edge(repeat_nom + tol_ticks);
    drive_edge(repeat_nom + tol_ticks - 1'b1);
    drive_edge(16'h5555);
    drive_edge(start_nom - tol_ticks + 1'b1);
    drive_edge(zero_nom + tol_ticks - 1'b1);
    drive_edge(one_nom - tol_ticks + 1'b1);
    drive_edge(one_nom + tol_ticks);
    drive_edge(start_nom + tol_ticks - 1'b1);
    drive_edge(16'hAAAA);
  endtask

  // start beats repeat, zero beats one when windows coincide
  task automatic test_overlap_priority();
    load_timing(16'd8000, 16'd8000, 16'd600, 16'd600, 16'd100);
    drive_edge(16'd8000);
    drive_edge(16'd650);
    drive_edge(16'd599);
    drive_edge(16'd40000);
    drive_edge(16'd8099);
  endtask

  task automatic test_empty_windows();
    wait_decoder_idle();
    cfg_write(necd_pkg::REG_TOLERANCE, 16'd0);
    drive_edge(zero_nom);
    drive_edge(start_nom);
    drive_edge(16'd0);
  endtask

  task automatic test_extreme_settings();
    load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drive_edge(16'h0000);
    drive_edge(16'hFFFF);
    drive_edge(16'h0001);
    drive_edge(16'h0000);
    load_timing(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001);
    drive_edge(16'h0000);
    drive_edge(16'h0001);
    drive_edge(16'h0000);
    drive_edge(16'h0000);
  endtask

  task automatic test_random_traffic();
    int          kind;
    int          pick;
    int          phase_end;
    logic [15:0] tl;
    logic [15:0] z;
    logic [15:0] o;
    logic [15:0] rp;
    logic [15:0] st;
    for (int p = 0; p < 6; p++) begin
      kind = (p == 0) ? 0 : (p % 2 == 1) ? 1 : (p == 2) ? 2 : 3;
      case (kind)
        0: load_timing(necd_pkg::START_NOM_RST, necd_pkg::REPEAT_NOM_RST,
                       necd_pkg::ZERO_NOM_RST, necd_pkg::ONE_NOM_RST,
                       necd_pkg::TOLERANCE_RST);
        1: begin
          tl = 16'($urandom_range(1, 800));
          z  = 16'($urandom_range(tl, 4000));
          o  = 16'(int'(z) + 2 * int'(tl) + int'($urandom_range(0, 2000)));
          rp = 16'($urandom_range(o + 2 * tl, 30000));
          st = 16'($urandom_range(31000 + tl, 65535));
          load_timing(st, rp, z, o, tl);
        end
        2: load_timing(rand_tick(), rand_tick(), rand_tick(), rand_tick(),
                       16'($urandom_range(0, 4000)));
        default: load_timing(16'($urandom_range(30001, 65535)),
                             16'($urandom_range(6001, 30000)),
                             16'($urandom_range(0, 3000)),
                             16'($urandom_range(3001, 6000)), 16'd1);
      endcase
      // writes past the register list must leave the timing untouched
      cfg_write(necd_pkg::REG_TOLERANCE + necd_pkg::CFG_IDX_W'($urandom_range(1, 3)),
                rand_tick());
      phase_end = items_sent + 300;
      while (items_sent < phase_end) begin
        pick = int'($urandom_range(0, 99));
        if (pick < 65) begin
          send_frame($urandom_range(0, 4) == 0, $urandom_range(0, 9) == 0);
        end else if (pick < 80) begin
          if (dec_phase == necd_pkg::PH_IDLE) drive_edge(rand_tick());
          drive_edge(tick_in(repeat_nom));
        end else if (pick < 98) begin
          repeat ($urandom_range(1, 6)) drive_edge(rand_tick());
        end else begin
          wait_decoder_idle();
        end
      end
    end
  endtask

  // output stall: runs of none, light, heavy and periodic stall
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = int'($urandom_range(0, 3));
      stall_left = int'($urandom_range(32, 400));
    end
    stall_left--;
    stall_cyc++;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_cyc % 3 == 0);
    endcase
  end

  always @(posedge clk) begin
    edge_result_t got;
    edge_result_t want;
    got = {frame_ready, repeat_ready, check_failed, address_out, command_out};
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result beat: frame=%0b rep=%0b fail=%0b addr=%02h cmd=%02h",
                   got.frame, got.rep, got.fail, got.addr, got.cmd);
      end else begin
        want = pending_results.pop_front();
        if (got.frame !== want.frame || got.rep !== want.rep || got.fail !== want.fail ||
            got.addr !== want.addr || got.cmd !== want.cmd) begin
          err_count++;
          if (err_count <= 10) begin
            $display("result mismatch: exp frame=%0b rep=%0b fail=%0b addr=%02h cmd=%02h",
                     want.frame, want.rep, want.fail, want.addr, want.cmd);
            $display("                 got frame=%0b rep=%0b fail=%0b addr=%02h cmd=%02h",
                     got.frame, got.rep, got.fail, got.addr, got.cmd);
          end
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_window_edges();
    test_overlap_priority();
    test_empty_windows();
    test_extreme_settings();
    test_random_traffic();
    wait_decoder_idle();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      err_count++;
      $display("%0d expected results never arrived", pending_results.size());
    end
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/necd_pkg.sv
rtl/necd_classify.sv
rtl/necd_fifo.sv
rtl/necd_engine.sv
rtl/nec_ir_frame_decoder.sv
sim/nec_ir_frame_decoder_tb.sv
